/* rtl/lmc_pkg.sv */
`timescale 1ns / 1ps

package lmc_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int MAX_COLUMNS = 1024;
    localparam int MAX_ROWS    = 1024;
    localparam int COL_BITS    = $clog2(MAX_COLUMNS);
    localparam int ROW_BITS    = $clog2(MAX_ROWS);
    localparam int COUNT_BITS  = 11;
    localparam int TALLY_BITS  = 21;
    localparam int INC_BITS    = 3;

    localparam logic [0:0] REG_ROW_COUNT    = 1'b0;
    localparam logic [0:0] REG_COLUMN_COUNT = 1'b1;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;

    localparam sample_t PAD_VALUE = sample_t'(32767);

    // one window column, top row is the oldest line
    typedef struct packed {
        sample_t top;
        sample_t mid;
        sample_t bot;
    } win_col_t;

    localparam win_col_t PAD_COL = '{top: PAD_VALUE, mid: PAD_VALUE, bot: PAD_VALUE};

    // position facts of one item, fixed when it is accepted
    typedef struct packed {
        logic first_col;
        logic has_left;
        logic row_above;
        logic two_rows_above;
        logic row_end;
        logic last_row;
    } step_flags_t;

    // center of the middle row strictly below its eight neighbors
    function automatic logic mid_is_min(win_col_t l, win_col_t c, win_col_t r);
        sample_t v;
        v = c.mid;
        return (v < l.top) && (v < l.mid) && (v < l.bot) && (v < c.top) &&
               (v < c.bot) && (v < r.top) && (v < r.mid) && (v < r.bot);
    endfunction

    // center of the bottom row, with a padding row below it
    function automatic logic bot_is_min(win_col_t l, win_col_t c, win_col_t r);
        sample_t v;
        v = c.bot;
        return (v < l.mid) && (v < l.bot) && (v < c.mid) && (v < r.mid) &&
               (v < r.bot) && (v < PAD_VALUE);
    endfunction

endpackage

/* rtl/lmc_line_store.sv */
`timescale 1ns / 1ps

module lmc_line_store
    import lmc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                rd_en,
    input  logic [COL_BITS-1:0] rd_addr,
    input  logic                wr_en,
    input  logic [COL_BITS-1:0] wr_addr,
    input  sample_t             wr_upper,
    input  sample_t             wr_lower,
    output sample_t             rd_upper,
    output sample_t             rd_lower
);

    logic [2*SAMPLE_BITS-1:0] mem [MAX_COLUMNS];
    logic [2*SAMPLE_BITS-1:0] rd_data_reg;
    logic [2*SAMPLE_BITS-1:0] fwd_data_reg;
    logic                     fwd_sel_reg;
    logic [2*SAMPLE_BITS-1:0] rd_word;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= {wr_upper, wr_lower};
        end
        if (rd_en)
        begin
            rd_data_reg  <= mem[rd_addr];
            fwd_data_reg <= {wr_upper, wr_lower};
        end
    end

    // same column read while it is being written
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_sel_reg <= 1'b0;
        end
        else if (rd_en)
        begin
            fwd_sel_reg <= wr_en && (rd_addr == wr_addr);
        end
    end

    assign rd_word  = fwd_sel_reg ? fwd_data_reg : rd_data_reg;
    assign rd_upper = sample_t'(rd_word[2*SAMPLE_BITS-1:SAMPLE_BITS]);
    assign rd_lower = sample_t'(rd_word[SAMPLE_BITS-1:0]);

endmodule

/* rtl/lmc_window.sv */
`timescale 1ns / 1ps

module lmc_window
    import lmc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  step_flags_t         flags,
    input  win_col_t            new_col,
    output logic [INC_BITS-1:0] inc
);

    win_col_t left_reg;
    win_col_t center_reg;
    win_col_t left_eff;
    win_col_t center_eff;
    logic     hit_a_mid;
    logic     hit_a_bot;
    logic     hit_b_mid;
    logic     hit_b_bot;

    always_comb
    begin
        left_eff   = flags.first_col ? PAD_COL : left_reg;
        center_eff = flags.first_col ? PAD_COL : center_reg;
        hit_a_mid  = flags.has_left && flags.row_above &&
                     mid_is_min(left_eff, center_eff, new_col);
        hit_a_bot  = flags.has_left && flags.last_row &&
                     bot_is_min(left_eff, center_eff, new_col);
        hit_b_mid  = flags.row_end && flags.row_above &&
                     mid_is_min(center_eff, new_col, PAD_COL);
        hit_b_bot  = flags.row_end && flags.last_row &&
                     bot_is_min(center_eff, new_col, PAD_COL);
        inc = INC_BITS'(hit_a_mid) + INC_BITS'(hit_a_bot) +
              INC_BITS'(hit_b_mid) + INC_BITS'(hit_b_bot);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg   <= PAD_COL;
            center_reg <= PAD_COL;
        end
        else if (advance)
        begin
            left_reg   <= center_eff;
            center_reg <= new_col;
        end
    end

endmodule

/* rtl/local_minimum_counter_core.sv */
`timescale 1ns / 1ps

// Counts strict 3x3 local minima over a frame of signed samples in raster
// order, with the frame padded by 32767 on every side; an equal neighbor
// disqualifies a sample. One sample is taken every clock unless stalled:
// the line store does one read and one write per cycle, and the window
// compare sits between the memory read register and the tally. A frame's
// count is registered and held until taken; in_stall rises only while a
// finished count waits and the next frame end is ready behind it. row_count
// and column_count (0 acts as 1, above 1024 acts as 1024) must be written
// only while no frame is in progress; the block does not enforce it.

module local_minimum_counter_core
    import lmc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [SAMPLE_BITS-1:0] sample,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [TALLY_BITS-1:0] minima_found,
    input  logic                  write_enable,
    input  logic [0:0]            reg_index,
    input  logic [COUNT_BITS-1:0] write_data
);

    logic [COUNT_BITS-1:0] row_count_reg;
    logic [COUNT_BITS-1:0] column_count_reg;
    logic [COUNT_BITS-1:0] rows_eff;
    logic [COUNT_BITS-1:0] cols_eff;
    logic [COL_BITS-1:0]   col_pos_reg;
    logic [ROW_BITS-1:0]   row_pos_reg;
    step_flags_t           flags_next;
    logic                  in_accept;

    logic                  s1_valid_reg;
    step_flags_t           s1_flags_reg;
    sample_t               s1_sample_reg;
    logic [COL_BITS-1:0]   s1_col_reg;
    logic                  s1_frame_end;
    logic                  s1_hold;
    logic                  s1_advance;

    sample_t               mem_upper;
    sample_t               mem_lower;
    win_col_t              new_col;
    logic [INC_BITS-1:0]   inc;

    logic [TALLY_BITS-1:0] tally_reg;
    logic [TALLY_BITS-1:0] tally_sum;
    logic                  out_valid_reg;
    logic [TALLY_BITS-1:0] result_reg;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg    <= COUNT_BITS'(MAX_ROWS);
            column_count_reg <= COUNT_BITS'(MAX_COLUMNS);
        end
        else if (write_enable)
        begin
            unique case (reg_index)
                REG_ROW_COUNT:    row_count_reg    <= write_data;
                REG_COLUMN_COUNT: column_count_reg <= write_data;
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        if (row_count_reg == '0)
            rows_eff = COUNT_BITS'(1);
        else if (row_count_reg > COUNT_BITS'(MAX_ROWS))
            rows_eff = COUNT_BITS'(MAX_ROWS);
        else
            rows_eff = row_count_reg;

        if (column_count_reg == '0)
            cols_eff = COUNT_BITS'(1);
        else if (column_count_reg > COUNT_BITS'(MAX_COLUMNS))
            cols_eff = COUNT_BITS'(MAX_COLUMNS);
        else
            cols_eff = column_count_reg;

        flags_next.first_col      = (col_pos_reg == '0);
        flags_next.has_left       = (col_pos_reg != '0);
        flags_next.row_above      = (row_pos_reg != '0);
        flags_next.two_rows_above = (row_pos_reg > ROW_BITS'(1));
        flags_next.row_end        = (COUNT_BITS'(col_pos_reg) + COUNT_BITS'(1) >= cols_eff);
        flags_next.last_row       = (COUNT_BITS'(row_pos_reg) + COUNT_BITS'(1) >= rows_eff);
    end

    // handshake
    assign s1_frame_end = s1_flags_reg.row_end && s1_flags_reg.last_row;
    assign s1_hold      = s1_valid_reg && s1_frame_end && out_valid_reg && out_stall;
    assign s1_advance   = s1_valid_reg && !s1_hold;
    assign in_stall     = s1_hold;
    assign in_accept    = in_valid && !in_stall;

    // raster position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_pos_reg <= '0;
            row_pos_reg <= '0;
        end
        else if (in_accept)
        begin
            if (flags_next.row_end)
            begin
                col_pos_reg <= '0;
                row_pos_reg <= flags_next.last_row ? '0 : row_pos_reg + ROW_BITS'(1);
            end
            else
            begin
                col_pos_reg <= col_pos_reg + COL_BITS'(1);
            end
        end
    end

    // compare stage input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_flags_reg  <= flags_next;
            s1_sample_reg <= sample_t'(sample);
            s1_col_reg    <= col_pos_reg;
        end
    end

    lmc_line_store u_line_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (in_accept),
        .rd_addr  (col_pos_reg),
        .wr_en    (s1_advance),
        .wr_addr  (s1_col_reg),
        .wr_upper (mem_lower),
        .wr_lower (s1_sample_reg),
        .rd_upper (mem_upper),
        .rd_lower (mem_lower)
    );

    always_comb
    begin
        new_col.top = s1_flags_reg.two_rows_above ? mem_upper : PAD_VALUE;
        new_col.mid = s1_flags_reg.row_above ? mem_lower : PAD_VALUE;
        new_col.bot = s1_sample_reg;
    end

    lmc_window u_window (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (s1_advance),
        .flags   (s1_flags_reg),
        .new_col (new_col),
        .inc     (inc)
    );

    // tally and result register
    assign tally_sum = tally_reg + TALLY_BITS'(inc);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tally_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_advance && s1_frame_end)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (s1_advance)
            begin
                if (s1_frame_end)
                begin
                    tally_reg <= '0;
                end
                else
                begin
                    tally_reg <= tally_sum;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance && s1_frame_end)
        begin
            result_reg <= tally_sum;
        end
    end

    assign out_valid    = out_valid_reg;
    assign minima_found = result_reg;

endmodule

/* sim/tb_local_minimum_counter_core.sv */
`timescale 1ns / 1ps

module tb_local_minimum_counter_core;
    import lmc_pkg::*;

    typedef sample_t trio_t [3];

    class minima_scoreboard;
        sample_t                upper_line [MAX_COLUMNS];
        sample_t                lower_line [MAX_COLUMNS];
        trio_t                  nbhd [3];
        int unsigned            rows_set;
        int unsigned            cols_set;
        int unsigned            row_at;
        int unsigned            col_at;
        logic [TALLY_BITS-1:0]  tally;
        logic [TALLY_BITS-1:0]  counts_due [$];
        int                     errors;

        function new();
            rows_set = MAX_ROWS;
            cols_set = MAX_COLUMNS;
            row_at = 0;
            col_at = 0;
            tally = '0;
            errors = 0;
            pad_window();
        endfunction

        function int unsigned clamp(int unsigned v, int unsigned top);
            if (v == 0)
                return 1;
            return (v > top) ? top : v;
        endfunction

        function int frame_size();
            return clamp(rows_set, MAX_ROWS) * clamp(cols_set, MAX_COLUMNS);
        endfunction

        function int pending();
            return counts_due.size();
        endfunction

        function void pad_window();
            for (int a = 0; a < 3; a++)
                for (int b = 0; b < 3; b++)
                    nbhd[a][b] = PAD_VALUE;
        endfunction

        function void shift_col(sample_t top, sample_t mid, sample_t bot);
            trio_t col;
            col = '{top, mid, bot};
            for (int a = 0; a < 3; a++)
            begin
                nbhd[a][0] = nbhd[a][1];
                nbhd[a][1] = nbhd[a][2];
                nbhd[a][2] = col[a];
            end
        endfunction

        function bit below_all(trio_t t, trio_t m, trio_t b);
            sample_t c;
            c = m[1];
            return c < t[0] && c < t[1] && c < t[2] && c < m[0] && c < m[2] &&
                   c < b[0] && c < b[1] && c < b[2];
        endfunction

        // middle column of the window, for the row above and the bottom row
        function void judge(bit last_row);
            trio_t pad_trio;
            pad_trio = '{PAD_VALUE, PAD_VALUE, PAD_VALUE};
            if (row_at >= 1 && below_all(nbhd[0], nbhd[1], nbhd[2]))
                tally = tally + 1'b1;
            if (last_row && below_all(nbhd[1], nbhd[2], pad_trio))
                tally = tally + 1'b1;
        endfunction

        function void take_sample(sample_t v);
            int unsigned ci;
            bit          row_end;
            bit          last_row;
            sample_t     up;
            sample_t     lo;
            ci = col_at % MAX_COLUMNS;
            row_end = (col_at + 1 >= clamp(cols_set, MAX_COLUMNS));
            last_row = (row_at + 1 >= clamp(rows_set, MAX_ROWS));
            if (col_at == 0)
                pad_window();
            up = (row_at >= 2) ? upper_line[ci] : PAD_VALUE;
            lo = (row_at >= 1) ? lower_line[ci] : PAD_VALUE;
            upper_line[ci] = lower_line[ci];
            lower_line[ci] = v;
            shift_col(up, lo, v);
            if (col_at >= 1)
                judge(last_row);
            if (row_end)
            begin
                shift_col(PAD_VALUE, PAD_VALUE, PAD_VALUE);
                judge(last_row);
            end
            if (!row_end)
                col_at = col_at + 1;
            else
            begin
                col_at = 0;
                if (!last_row)
                    row_at = row_at + 1;
                else
                begin
                    counts_due.push_back(tally);
                    row_at = 0;
                    tally = '0;
                    pad_window();
                end
            end
        endfunction

        task report(string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            errors++;
        endtask

        task check_count(logic [TALLY_BITS-1:0] got);
            logic [TALLY_BITS-1:0] want;
            if (counts_due.size() == 0)
                report($sformatf("minima_found %0d with no frame pending", got));
            else
            begin
                want = counts_due.pop_front();
                if (got !== want)
                    report($sformatf("minima_found %0d, expected %0d", got, want));
            end
        endtask
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_stall;
    logic [SAMPLE_BITS-1:0] sample;
    logic                   out_valid;
    logic                   out_stall;
    logic [TALLY_BITS-1:0]  minima_found;
    logic                   write_enable;
    logic [0:0]             reg_index;
    logic [COUNT_BITS-1:0]  write_data;

    minima_scoreboard sb = new();
    bit               idle_on = 1'b1;
    int               hold_request = 0;

    local_minimum_counter_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .sample       (sample),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .minima_found (minima_found),
        .write_enable (write_enable),
        .reg_index    (reg_index),
        .write_data   (write_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 19);
        if (r < 12)
            return 0;
        if (r < 18)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic sample_t next_sample(int mode);
        int pick;
        pick = $urandom_range(0, 7);
        if (mode == 0)
            return sample_t'($urandom);
        if (mode == 1 || pick < 3)
            return sample_t'(int'($urandom_range(0, 4)) - 2);
        if (pick == 3)
            return sample_t'(-32768);
        if (pick == 4)
            return PAD_VALUE;
        return sample_t'($urandom);
    endfunction

    // called and returns at a falling edge
    task automatic send_sample(sample_t v);
        int gap;
        gap = idle_on ? gap_len() : 0;
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid = 1'b1;
        sample = v;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.take_sample(v);
        @(negedge clk);
    endtask

    task automatic send_frame(int mode);
        repeat (sb.frame_size())
            send_sample(next_sample(mode));
    endtask

    task automatic drain();
        in_valid = 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
    endtask

    task automatic set_size(int unsigned rows, int unsigned cols);
        drain();
        repeat (4) @(negedge clk);
        write_enable = 1'b1;
        reg_index = REG_ROW_COUNT;
        write_data = COUNT_BITS'(rows);
        @(negedge clk);
        reg_index = REG_COLUMN_COUNT;
        write_data = COUNT_BITS'(cols);
        @(negedge clk);
        write_enable = 1'b0;
        sb.rows_set = rows;
        sb.cols_set = cols;
    endtask

    // result side: random stalls, plus one long hold on request
    initial
    begin
        int hold_left;
        int run_left;
        bit hold_taken;
        hold_left = 0;
        run_left = 0;
        hold_taken = 1'b0;
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
                sb.check_count(minima_found);
            @(negedge clk);
            if (hold_request > 0 && !hold_taken)
            begin
                hold_left = hold_request;
                hold_taken = 1'b1;
            end
            if (hold_left > 0)
            begin
                out_stall = 1'b1;
                hold_left--;
            end
            else if (!idle_on)
                out_stall = 1'b0;
            else if (run_left > 0)
                run_left--;
            else
            begin
                out_stall = ($urandom_range(0, 2) == 0);
                run_left = gap_len();
            end
        end
    end

    initial
    begin
        sample_t     peak [9];
        sample_t     flat [9];
        sample_t     strip [3];
        int          random_sent;
        int          frames_left;
        int unsigned rows;
        int unsigned cols;
        peak = '{0, 0, 0, 0, -5, 0, 0, 0, 0};
        flat = '{7, 7, 7, 7, 7, 7, 7, 7, 7};
        strip = '{5, -32768, 5};
        random_sent = 0;
        frames_left = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        sample = '0;
        write_enable = 1'b0;
        reg_index = REG_ROW_COUNT;
        write_data = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // single-sample frames at both ends of the range
        set_size(1, 1);
        send_sample(sample_t'(-32768));
        send_sample(PAD_VALUE);
        // isolated minimum, then a plateau where equal neighbors disqualify
        set_size(3, 3);
        foreach (peak[i])
            send_sample(peak[i]);
        foreach (flat[i])
            send_sample(flat[i]);
        set_size(1, 3);
        foreach (strip[i])
            send_sample(strip[i]);

        // zero counts act as one
        set_size(0, 6);
        send_frame(2);
        set_size(4, 0);
        send_frame(1);

        // result side blocked while every item ends a frame
        set_size(1, 1);
        idle_on = 1'b0;
        hold_request = 300;
        repeat (40)
            send_sample(next_sample(2));
        idle_on = 1'b1;

        while (random_sent < 430)
        begin
            idle_on = ($urandom_range(0, 3) != 0);
            rows = $urandom_range(0, 5);
            cols = $urandom_range(0, 8);
            if ($urandom_range(0, 9) == 0)
            begin
                rows = $urandom_range(0, 2);
                cols = $urandom_range(30, 70);
            end
            set_size(rows, cols);
            frames_left = $urandom_range(1, 3);
            while (frames_left > 0 && random_sent < 430)
            begin
                send_frame($urandom_range(0, 2));
                random_sent += sb.frame_size();
                frames_left--;
            end
        end

        drain();
        repeat (10) @(negedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

/* local_minimum_counter_core.f */
rtl/lmc_pkg.sv
rtl/lmc_line_store.sv
rtl/lmc_window.sv
rtl/local_minimum_counter_core.sv
sim/tb_local_minimum_counter_core.sv
